### hw/rtl/svgr_pkg.sv
// Shared types and constants for the sample voice gain ramp.
// No dependencies.
`timescale 1ns / 1ps
package svgr_pkg;
  localparam int unsigned MAX_FRAMES_DEF = 65536;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_TICK   = 3'd2;
  localparam logic [2:0] OP_EXCITE = 3'd3;
  localparam logic [2:0] OP_TARGET = 3'd4;
  localparam logic [2:0] OP_FADE   = 3'd5;
  localparam logic [2:0] OP_STOP   = 3'd6;

  localparam logic [2:0] REG_START_FRAME = 3'd0;
  localparam logic [2:0] REG_FRAMES      = 3'd1;
  localparam logic [2:0] REG_STEP        = 3'd2;
  localparam logic [2:0] REG_RAMP        = 3'd3;
  localparam logic [2:0] REG_FADE        = 3'd4;
  localparam logic [2:0] REG_TEPS        = 3'd5;
  localparam logic [2:0] REG_GEPS        = 3'd6;

  typedef struct packed {
    logic        start;
    logic [16:0] dividend;   // magnitude
    logic        negative;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] quotient;   // signed, forced nonzero for a nonzero dividend
  } div_rsp_t;
endpackage

### hw/rtl/svgr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module svgr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/svgr_div.sv
// Restoring divider for the gain ramp increment, one quotient bit a cycle.
// Depends on svgr_pkg.
`timescale 1ns / 1ps
module svgr_div (
  input  logic              clk,
  input  logic              rst,
  input  svgr_pkg::div_req_t req,
  output svgr_pkg::div_rsp_t rsp
);
  import svgr_pkg::*;

  logic [16:0] quo;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic        neg;
  logic        nz;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [17:0] trial;
  logic [16:0] q_fix;

  assign trial = {rem, quo[16]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= (req.divisor == '0) ? 16'd1 : req.divisor;
        neg  <= req.negative;
        nz   <= (req.dividend != '0);
        cnt  <= 5'd17;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial[16:0];
          quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= {rem[15:0], quo[16]};
          quo <= {quo[15:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_fix = (quo == '0 && nz) ? 17'd1 : quo;
    rsp.done = done;
    rsp.quotient = neg ? -{7'd0, q_fix} : {7'd0, q_fix};
  end
endmodule

### hw/rtl/sample_voice_gain_ramp.sv
// Stereo sample-playback voice: interpolation, gain ramp, pan, saturation.
// Depends on svgr_pkg, svgr_ram, svgr_div.
// Load, stop, unknown and ignored words and idle or past-end ticks go from S_GAIN to S_SEND;
// an active tick runs S_RD0, S_RD1, S_INT, S_MUL, S_MUL2 and S_OUT; start/excite/target/fade
// wait in S_DIV for the 17-step increment divider. One word in flight; the next word is
// taken only after the result word is accepted.
// Tick reads two frames from the sample RAM on successive cycles.
// Reset (rst, synchronous) clears voice state and sets the registers to their defaults; sample RAM undefined.
`timescale 1ns / 1ps
module sample_voice_gain_ramp #(
  parameter int unsigned MAX_FRAMES = svgr_pkg::MAX_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[2:0], sample_addr[18:3], sample_left[34:19], sample_right[50:35],
  // gain_value[66:51], pan_left[82:67], pan_right[98:83], zero pad to 104
  input  logic [103:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_left[15:0], out_right[31:16], has_sample[32], voice_active[33], pad to 40
  output logic [39:0] m_tdata
);
  import svgr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAMES);

  localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_RD1 = 4'd2, S_INT = 4'd3,
                         S_GAIN = 4'd4, S_MUL = 4'd5, S_OUT = 4'd6, S_DIV = 4'd7,
                         S_SEND = 4'd8, S_MUL2 = 4'd9;

  logic [15:0] start_frame;
  logic [16:0] frames_loaded;
  logic [19:0] position_step;
  logic [15:0] ramp_frames, fade_ticks, target_epsilon, gain_epsilon;

  logic [3:0]  state;
  logic [31:0] play_position;
  logic [15:0] current_gain, target_gain;
  logic [23:0] gain_increment;
  logic        fading_flag, active_flag;
  logic [31:0] pan_pair;

  logic [2:0]  op;
  logic [15:0] gv, pl_in, pr_in;
  logic [39:0] result;
  logic        out_full;

  logic        ram_we;
  logic [31:0] ram_rd;
  logic [AW-1:0] ram_raddr;
  logic [31:0] frame_a;
  logic        interp;
  logic        carry;
  logic signed [16:0] samp_l, samp_r;
  logic signed [33:0] prod_l, prod_r;
  logic signed [50:0] full_l, full_r;
  div_req_t    dreq;
  div_rsp_t    drsp;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      REG_START_FRAME: prdata = {16'd0, start_frame};
      REG_FRAMES:      prdata = {15'd0, frames_loaded};
      REG_STEP:        prdata = {12'd0, position_step};
      REG_RAMP:        prdata = {16'd0, ramp_frames};
      REG_FADE:        prdata = {16'd0, fade_ticks};
      REG_TEPS:        prdata = {16'd0, target_epsilon};
      REG_GEPS:        prdata = {16'd0, gain_epsilon};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_frame <= '0; frames_loaded <= '0; position_step <= 20'd65536;
      ramp_frames <= 16'd480; fade_ticks <= 16'd480;
      target_epsilon <= 16'd1; gain_epsilon <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_START_FRAME: start_frame <= pwdata[15:0];
        REG_FRAMES:      frames_loaded <= pwdata[16:0];
        REG_STEP:        position_step <= pwdata[19:0];
        REG_RAMP:        ramp_frames <= pwdata[15:0];
        REG_FADE:        fade_ticks <= pwdata[15:0];
        REG_TEPS:        target_epsilon <= pwdata[15:0];
        REG_GEPS:        gain_epsilon <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // effective frame count, clamped to memory depth
  logic [20:0] nf;
  assign nf = ({4'd0, frames_loaded} > 21'(MAX_FRAMES)) ? 21'(MAX_FRAMES)
                                                       : {4'd0, frames_loaded};
  logic [20:0] p0;
  assign p0 = {5'd0, play_position[31:16]};

  assign ram_we = (state == S_IDLE) && s_tvalid && s_tready &&
                  (s_tdata[2:0] == OP_LOAD) && ({5'd0, s_tdata[18:3]} < 21'(MAX_FRAMES));
  assign ram_raddr = (state == S_RD0) ? AW'(play_position[31:16])
                                      : AW'(play_position[31:16] + 16'd1);

  svgr_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(AW'(s_tdata[18:3])),
    .wdata({s_tdata[50:35], s_tdata[34:19]}), .raddr(ram_raddr), .rdata(ram_rd));

  svgr_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_tready = (state == S_IDLE) && !out_full;
  assign m_tvalid = out_full;
  assign m_tdata  = result;

  // interpolation terms: a*65536 + (b-a)*frac + 2^15, arithmetic shift by 16
  logic signed [16:0] dl, dr;
  logic signed [34:0] il, ir;
  assign dl = $signed({ram_rd[15], ram_rd[15:0]}) - $signed({frame_a[15], frame_a[15:0]});
  assign dr = $signed({ram_rd[31], ram_rd[31:16]}) - $signed({frame_a[31], frame_a[31:16]});
  assign il = ($signed({{3{frame_a[15]}}, frame_a[15:0], 16'd0}))
            + dl * $signed({1'b0, play_position[15:0]}) + 35'sd32768;
  assign ir = ($signed({{3{frame_a[31]}}, frame_a[31:16], 16'd0}))
            + dr * $signed({1'b0, play_position[15:0]}) + 35'sd32768;

  // gain step with clamp at target
  logic signed [24:0] g;
  logic signed [24:0] g_cl;
  logic               clamp_hit;
  always_comb begin
    g = $signed({9'd0, current_gain}) + $signed({gain_increment[23], gain_increment});
    clamp_hit = (!gain_increment[23] && gain_increment != '0 &&
                 g > $signed({9'd0, target_gain})) ||
                (gain_increment[23] && g < $signed({9'd0, target_gain}));
    g_cl = clamp_hit ? $signed({9'd0, target_gain}) : g;
    if (g_cl < 0) g_cl = '0;
    if (g_cl > 25'sd65535) g_cl = 25'sd65535;
  end

  function automatic logic [15:0] sat_round(input logic signed [50:0] v);
    logic signed [50:0] t;
    logic signed [26:0] q;
    begin
      t = v + 51'sd8388608;
      q = t[50:24];
      if (q > 27'sd32767) sat_round = 16'h7fff;
      else if (q < -27'sd32768) sat_round = 16'h8000;
      else sat_round = q[15:0];
    end
  endfunction

  logic [16:0] ex_sum;
  logic [15:0] ex_t;
  assign ex_sum = {1'b0, current_gain} + {1'b0, gv};
  assign ex_t = ex_sum[16] ? 16'hffff : ex_sum[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_full <= 1'b0;
      play_position <= '0; current_gain <= '0; target_gain <= '0;
      gain_increment <= '0; fading_flag <= 1'b0; active_flag <= 1'b0;
      pan_pair <= '0; dreq <= '0;
    end else begin
      // the divider start pulse is raised only from S_GAIN; drop it everywhere else
      if (state != S_GAIN) dreq.start <= 1'b0;
      if (out_full && m_tready) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op <= s_tdata[2:0]; gv <= s_tdata[66:51];
            pl_in <= s_tdata[82:67]; pr_in <= s_tdata[98:83];
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          result <= '0;
          state <= S_SEND;
          case (op)
            OP_START: begin
              play_position <= {start_frame, 16'd0};
              current_gain <= '0; target_gain <= gv; fading_flag <= 1'b0;
              pan_pair <= {pr_in, pl_in};
              active_flag <= nf > {5'd0, start_frame};
              dreq <= '{start: 1'b1, dividend: {1'b0, gv}, negative: 1'b0,
                        divisor: ramp_frames};
              state <= S_DIV;
            end
            OP_TICK: begin
              if (active_flag) begin
                if (p0 >= nf) active_flag <= 1'b0;
                else state <= S_RD0;
              end
            end
            OP_EXCITE: begin
              if (active_flag && gv != '0 && ex_t > target_gain) begin
                target_gain <= ex_t; fading_flag <= 1'b0;
                dreq <= '{start: 1'b1, dividend: {1'b0, ex_t - current_gain},
                          negative: 1'b0, divisor: ramp_frames};
                state <= S_DIV;
              end
            end
            OP_TARGET: begin
              if (active_flag) begin
                if (gv <= target_epsilon) begin
                  target_gain <= '0; fading_flag <= 1'b1;
                  dreq <= '{start: 1'b1, dividend: {1'b0, current_gain},
                            negative: 1'b1, divisor: ramp_frames};
                end else begin
                  target_gain <= gv; fading_flag <= 1'b0;
                  dreq <= '{start: 1'b1,
                            dividend: (gv >= current_gain) ? {1'b0, gv - current_gain}
                                                           : {1'b0, current_gain - gv},
                            negative: gv < current_gain, divisor: ramp_frames};
                end
                state <= S_DIV;
              end
            end
            OP_FADE: begin
              if (active_flag) begin
                target_gain <= '0; fading_flag <= 1'b1;
                dreq <= '{start: 1'b1, dividend: {1'b0, current_gain},
                          negative: 1'b1, divisor: fade_ticks};
                state <= S_DIV;
              end
            end
            OP_STOP: begin
              active_flag <= 1'b0; fading_flag <= 1'b0; current_gain <= '0;
              target_gain <= '0; gain_increment <= '0;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (drsp.done) begin
            gain_increment <= drsp.quotient;
            state <= S_SEND;
          end
        end
        S_RD0: begin
          interp <= (p0 + 21'd1) < nf;
          state <= S_RD1;
        end
        S_RD1: begin
          frame_a <= ram_rd;
          state <= S_INT;
        end
        S_INT: begin
          if (interp) begin
            samp_l <= 17'(il >>> 16); samp_r <= 17'(ir >>> 16);
          end else begin
            samp_l <= $signed({frame_a[15], frame_a[15:0]});
            samp_r <= $signed({frame_a[31], frame_a[31:16]});
          end
          {carry, play_position} <= {1'b0, play_position} + {13'd0, position_step};
          current_gain <= g_cl[15:0];
          if (clamp_hit) gain_increment <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod_l <= samp_l * $signed({1'b0, current_gain});
          prod_r <= samp_r * $signed({1'b0, current_gain});
          state <= S_MUL2;
        end
        S_MUL2: begin
          full_l <= prod_l * $signed({1'b0, pan_pair[15:0]});
          full_r <= prod_r * $signed({1'b0, pan_pair[31:16]});
          state <= S_OUT;
        end
        S_OUT: begin
          result[15:0] <= sat_round(full_l);
          result[31:16] <= sat_round(full_r);
          result[32] <= 1'b1;
          if ((fading_flag && current_gain <= gain_epsilon) || carry) begin
            active_flag <= 1'b0;
            if (fading_flag && current_gain <= gain_epsilon) current_gain <= '0;
          end
          state <= S_SEND;
        end
        S_SEND: begin
          result[33] <= active_flag;
          result[39:34] <= '0;
          out_full <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // S_RD1 latches frame a while frame b is being read; frame a arrives in S_RD1
  // because the sample RAM registers the read that S_RD0 issues.

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("accepted while busy");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
  a_send_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |=> (state == S_IDLE)) else $error("send not followed by idle");
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_GAIN && op == OP_STOP) |=> (!active_flag && current_gain == '0))
    else $error("stop left voice active");
endmodule
